/* src/bethe_energy_loss_rk4_assert.svh */
// Assertion macros for the energy-loss integrator.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef BETHE_ENERGY_LOSS_RK4_ASSERT_SVH
`define BETHE_ENERGY_LOSS_RK4_ASSERT_SVH

`ifndef SYNTHESIS
// Check that a property holds in the same cycle, masked during reset.
`define BEL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition implies another one in the next cycle.
`define BEL_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define BEL_ASSERT(label, prop, msg)
`define BEL_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

/* src/bel_pkg.sv */
package bel_pkg;

  localparam int ENERGY_W            = 48;
  localparam int STOP_W              = 16;
  localparam int CFG_DATA_W          = 48;
  localparam int CFG_INDEX_W         = 2;
  localparam int DEF_FRAC_BITS       = 32;
  localparam int DEF_STEP_COUNT_BITS = 16;
  localparam int STEP_COUNT_RESET    = 1000;

  localparam logic [63:0] LN2_Q63  = 64'h58B9_0BFB_E8E7_BCD5;
  localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] TWO_Q32  = 64'h0000_0002_0000_0000;
  localparam logic [63:0] W_CAP    = 64'h4000_0000_0000_0000;
  localparam logic [63:0] SLOPE_CAP = 64'h0400_0000_0000_0000;
  localparam logic [ENERGY_W-1:0] E_MAX = '1;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOSS_SCALE = 2'd0,
    REG_INV_MASS   = 2'd1,
    REG_AR_SCALE   = 2'd2,
    REG_STEP_COUNT = 2'd3
  } cfg_reg_t;

  // Clamp a signed energy into the unsigned energy range
  function automatic logic [ENERGY_W-1:0] clamp_e(input logic signed [62:0] v);
    logic [ENERGY_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({15'b0, E_MAX})) begin
      r = E_MAX;
    end else begin
      r = v[ENERGY_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/bethe_energy_loss_rk4.sv */
// Each input is integrated over step_count RK4 steps; when step_count is zero the start energy
// is offered as the result directly. Each step takes four slope evaluations, short while the
// stopping power is zero, plus a division by six.
// One item at a time, taken once the result is in the output register; the 32x32 multiplier
// builds each 64x64 product from partial products, and the divider is bit-serial.
// Reset (rst, synchronous): sequencer idle, no result pending, configuration registers cleared, step_count 1000.
`include "bethe_energy_loss_rk4_assert.svh"

module bethe_energy_loss_rk4 #(
  parameter int ENERGY_FRAC_BITS = bel_pkg::DEF_FRAC_BITS,
  parameter int STEP_COUNT_BITS  = bel_pkg::DEF_STEP_COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bel_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bel_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bel_pkg::ENERGY_W-1:0]        start_energy,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bel_pkg::ENERGY_W-1:0]        final_energy,
  output logic                                stopped,
  output logic [bel_pkg::STOP_W-1:0]          stop_step
);
  import bel_pkg::*;

  localparam int SC_W = (STEP_COUNT_BITS < STOP_W) ? STEP_COUNT_BITS : STOP_W;
  localparam logic [6:0] TT_SHIFT  = 7'(ENERGY_FRAC_BITS);
  localparam logic [6:0] MAG_SHIFT = 7'(72 - ENERGY_FRAC_BITS);
  localparam logic [6:0] DIV_LAST  = 7'd95;
  // ceil(2^63 / 3): exact floor division by three for operands below 2^61
  localparam logic [63:0] RECIP3_Q63 = 64'h2AAA_AAAA_AAAA_AAAB;

  typedef enum logic [4:0] {
    IDLE, SL_TT, SL_W, SL_AR, SL_CHK, LN_NORM, LN_BIT, SL_B2, SL_K, SL_G, SL_MAG,
    ST_NEXT, ST_UPD, FINISH, MUL, DIV
  } state_t;

  state_t state, ret;

  // Configuration registers
  logic [47:0]     loss_scale;
  logic [31:0]     inv_mass;
  logic [31:0]     ar_scale;
  logic [SC_W-1:0] step_count;

  // Shared multiplier: 64x64 product built from four 32x32 partial products
  logic [63:0]  ma, mb, prod;
  logic [127:0] pacc;
  logic [2:0]   mcnt;
  logic [6:0]   mshift;
  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [1:0]   pidx;
  logic [6:0]   psh;
  logic [127:0] prod_sh, mwide;
  logic [63:0]  mres;

  // Shared divider: restoring, one quotient bit per cycle
  logic [95:0] dq;
  logic [63:0] drem, dd;
  logic [6:0]  dcnt;
  logic [64:0] rem_sh, rem_sub;
  logic        ge;
  logic [63:0] dres;

  // Slope evaluation
  logic [62:0] w;
  logic [63:0] m;
  logic [5:0]  p;
  logic [31:0] frac;
  logic [4:0]  sqcnt;
  logic [37:0] lnv;
  logic [31:0] b2;
  logic        gpos;
  logic [63:0] sq_m;
  logic [31:0] frac_new;
  logic [5:0]  p_off;
  logic [63:0] wcap;
  logic [64:0] tsum;
  logic [64:0] ksum;
  logic [63:0] kk;
  logic signed [39:0] g;
  logic [39:0] ag;
  logic [58:0] mag;

  // Integration step
  logic [47:0]        e_base, e_cur;
  logic signed [59:0] k, khalf;
  logic signed [61:0] sum, ks, kd, sum_new, sum_abs;
  logic [1:0]         stage;
  logic [SC_W-1:0]    step_idx, stop_at;
  logic               neg, stop_f;
  logic signed [62:0] base_s, ev, enew;
  logic signed [61:0] q62;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == IDLE);

  // Multiplier partial products and saturating shift of the result
  always_comb begin
    a_part  = mcnt[1] ? ma[63:32] : ma[31:0];
    b_part  = mcnt[0] ? mb[63:32] : mb[31:0];
    pp      = 64'(a_part) * 64'(b_part);
    pidx    = 2'(mcnt - 3'd1);
    psh     = {2'(pidx[1]) + 2'(pidx[0]), 5'b0};
    prod_sh = 128'(prod) << psh;
    mwide   = pacc >> mshift;
    mres    = (|mwide[127:64]) ? '1 : mwide[63:0];
  end

  // Divider step and saturated quotient
  always_comb begin
    rem_sh  = {drem, dq[95]};
    rem_sub = rem_sh - {1'b0, dd};
    ge      = (rem_sh >= {1'b0, dd});
    dres    = ((dd == '0) || (|dq[95:64])) ? '1 : dq[63:0];
  end

  // Slope and step arithmetic around the shared units
  always_comb begin
    sq_m     = mres[63] ? {1'b0, mres[63:1]} : mres;
    frac_new = {frac[30:0], mres[63]};
    p_off    = p - 6'd32;
    wcap     = (mres > W_CAP) ? W_CAP : mres;
    tsum     = {1'b0, mres} + {1'b0, TWO_Q32};
    ksum     = {17'b0, loss_scale} + {1'b0, dres};
    kk       = ksum[64] ? '1 : ksum[63:0];
    g        = $signed({2'b0, lnv}) - $signed({8'b0, b2});
    ag       = g[39] ? 40'(-g) : 40'(g);
    mag      = (mres > SLOPE_CAP) ? SLOPE_CAP[58:0] : mres[58:0];
    khalf    = (k + $signed({59'b0, k[59]})) >>> 1;
    base_s   = $signed({15'b0, e_base});
    ev       = base_s + ((stage == 2'd2) ? 63'(k) : 63'(khalf));
    ks       = 62'(k);
    kd       = ((stage == 2'd1) || (stage == 2'd2)) ? (ks <<< 1) : ks;
    sum_new  = (stage == 2'd0) ? kd : (sum + kd);
    sum_abs  = sum_new[61] ? -sum_new : sum_new;
    q62      = $signed({1'b0, mres[60:0]});
    enew     = base_s + (neg ? 63'(-q62) : 63'(q62));
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_scale <= '0;
      inv_mass   <= '0;
      ar_scale   <= '0;
      step_count <= SC_W'(STEP_COUNT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LOSS_SCALE: loss_scale <= cfg_data;
        REG_INV_MASS:   inv_mass   <= cfg_data[31:0];
        REG_AR_SCALE:   ar_scale   <= cfg_data[31:0];
        REG_STEP_COUNT: step_count <= cfg_data[SC_W-1:0];
      endcase
    end
  end

  // Sequencer, shared units and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      ret       <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once transferred, unless a new one replaces it
      if (out_valid && out_ready && state != FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            e_base   <= start_energy;
            e_cur    <= start_energy;
            step_idx <= SC_W'(1);
            stage    <= 2'd0;
            stop_f   <= 1'b0;
            stop_at  <= '0;
            if (step_count == '0) begin
              state <= FINISH;
            end else begin
              state <= SL_TT;
            end
          end
        end
        SL_TT: begin
          ma <= 64'(e_cur); mb <= 64'(inv_mass); mshift <= TT_SHIFT;
          mcnt <= '0; pacc <= '0; ret <= SL_W; state <= MUL;
        end
        SL_W: begin
          ma <= mres; mb <= tsum[64] ? '1 : tsum[63:0]; mshift <= 7'd32;
          mcnt <= '0; pacc <= '0; ret <= SL_AR; state <= MUL;
        end
        SL_AR: begin
          w  <= wcap[62:0];
          ma <= 64'(ar_scale); mb <= wcap; mshift <= 7'd16;
          mcnt <= '0; pacc <= '0; ret <= SL_CHK; state <= MUL;
        end
        SL_CHK: begin
          // Log argument at most one: no energy loss
          if (mres <= ONE_Q32) begin
            k     <= '0;
            state <= ST_NEXT;
          end else begin
            if (mres[63]) begin
              m <= {1'b0, mres[63:1]};
              p <= 6'd63;
            end else begin
              m <= mres;
              p <= 6'd62;
            end
            state <= LN_NORM;
          end
        end
        LN_NORM: begin
          // Normalize the mantissa to bit 62, one position a cycle
          if (m[62]) begin
            frac <= '0; sqcnt <= '0;
            ma <= m; mb <= m; mshift <= 7'd62;
            mcnt <= '0; pacc <= '0; ret <= LN_BIT; state <= MUL;
          end else begin
            m <= m << 1;
            p <= p - 6'd1;
          end
        end
        LN_BIT: begin
          // One fraction bit of log2 per squaring
          frac <= frac_new;
          mcnt <= '0; pacc <= '0;
          state <= MUL;
          if (sqcnt == 5'd31) begin
            ma <= {26'b0, p_off, frac_new}; mb <= LN2_Q63; mshift <= 7'd63;
            ret <= SL_B2;
          end else begin
            sqcnt <= sqcnt + 5'd1;
            ma <= sq_m; mb <= sq_m; mshift <= 7'd62;
            ret <= LN_BIT;
          end
        end
        SL_B2: begin
          lnv  <= mres[37:0];
          dq   <= 96'(64'(w)) << 32; dd <= 64'(w) + ONE_Q32; drem <= '0;
          dcnt <= '0; ret <= SL_K; state <= DIV;
        end
        SL_K: begin
          b2   <= dres[31:0];
          dq   <= 96'(64'(loss_scale)) << 32; dd <= 64'(w); drem <= '0;
          dcnt <= '0; ret <= SL_G; state <= DIV;
        end
        SL_G: begin
          gpos <= !g[39] && (g != '0);
          ma <= kk; mb <= 64'(ag); mshift <= MAG_SHIFT;
          mcnt <= '0; pacc <= '0; ret <= SL_MAG; state <= MUL;
        end
        SL_MAG: begin
          k     <= gpos ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
          state <= ST_NEXT;
        end
        ST_NEXT: begin
          // Accumulate the weighted slope and set up the next stage
          sum <= sum_new;
          if (stage == 2'd3) begin
            // Divide by six: halve, then multiply by the reciprocal of three
            neg  <= sum_new[61];
            ma <= 64'(sum_abs[61:1]); mb <= RECIP3_Q63; mshift <= 7'd63;
            mcnt <= '0; pacc <= '0; ret <= ST_UPD; state <= MUL;
          end else begin
            e_cur <= clamp_e(ev);
            stage <= stage + 2'd1;
            state <= SL_TT;
          end
        end
        ST_UPD: begin
          stage <= 2'd0;
          if (enew <= 0) begin
            e_base  <= '0;
            stop_f  <= 1'b1;
            stop_at <= step_idx;
            state   <= FINISH;
          end else if (step_idx == step_count) begin
            e_base  <= clamp_e(enew);
            stop_at <= step_count;
            state   <= FINISH;
          end else begin
            e_base   <= clamp_e(enew);
            e_cur    <= clamp_e(enew);
            step_idx <= step_idx + SC_W'(1);
            state    <= SL_TT;
          end
        end
        FINISH: begin
          // Hold until the output register is free
          if (!out_valid || out_ready) begin
            final_energy <= e_base;
            stopped      <= stop_f;
            stop_step    <= STOP_W'(stop_at);
            out_valid    <= 1'b1;
            state        <= IDLE;
          end
        end
        MUL: begin
          if (mcnt != 3'd4) begin
            prod <= pp;
          end
          if (mcnt != 3'd0) begin
            pacc <= pacc + prod_sh;
          end
          if (mcnt == 3'd4) begin
            state <= ret;
          end else begin
            mcnt <= mcnt + 3'd1;
          end
        end
        DIV: begin
          drem <= ge ? rem_sub[63:0] : rem_sh[63:0];
          dq   <= {dq[94:0], ge};
          if (dcnt == DIV_LAST) begin
            state <= ret;
          end else begin
            dcnt <= dcnt + 7'd1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `BEL_ASSERT(a_stop_zero, out_valid && stopped |-> final_energy == '0, "stopped with energy")
  `BEL_ASSERT(a_stop_step, out_valid && !stopped |-> stop_step == STOP_W'(step_count), "bad step")
  `BEL_ASSERT(a_stop_nz, out_valid && stopped |-> stop_step != '0, "stop at step zero")
  `BEL_ASSERT(a_mcnt, state == MUL |-> mcnt <= 3'd4, "multiplier count overrun")
  `BEL_ASSERT_NEXT(a_start, in_valid && in_ready, state == SL_TT || state == FINISH, "bad start")

endmodule
